// ===== sv/http_chunked_body_decoder_core_assert.svh =====
// Assertion macros used by the checker of the body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a signal keeps its value in the cycle after a condition holds.
`define HCBD_ASSERT_STABLE(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// ===== sv/hcbd_pkg.sv =====
package hcbd_pkg;

  localparam int unsigned SIZE_WIDTH_DEF  = 32;
  localparam int unsigned HEADER_KEEP_DEF = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CLEN_W          = 32;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LENGTH = 1'd1;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_FINAL   = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;
  localparam logic [1:0] EV_FRAMING = 2'd3;

  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_DATA    = 7'b0000010,
    PH_SKIP1   = 7'b0000100,
    PH_SKIP2   = 7'b0001000,
    PH_TRAILER = 7'b0010000,
    PH_FIXED   = 7'b0100000,
    PH_IDLE    = 7'b1000000
  } phase_e;

  typedef enum logic [5:0] {
    HP_BLANK  = 6'b000001,
    HP_SIGN   = 6'b000010,
    HP_ZERO   = 6'b000100,
    HP_PREFIX = 6'b001000,
    HP_DIGITS = 6'b010000,
    HP_STOP   = 6'b100000
  } hex_step_e;

  typedef enum logic [2:0] {
    TL_EMPTY = 3'b001,
    TL_CR    = 3'b010,
    TL_OTHER = 3'b100
  } trailer_e;

  typedef struct packed {
    phase_e    phase;
    hex_step_e hex_step;
    trailer_e  trailer;
    logic      negative;
    logic      digits_seen;
  } ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              body_start;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        event_kind;
  } out_item_t;

endpackage

// ===== sv/hcbd_step.sv =====
module hcbd_step #(
  parameter int unsigned SIZE_WIDTH  = hcbd_pkg::SIZE_WIDTH_DEF,
  parameter int unsigned HEADER_KEEP = hcbd_pkg::HEADER_KEEP_DEF,
  localparam int unsigned ACC_W  = SIZE_WIDTH - 1,
  localparam int unsigned CNT_W  = (SIZE_WIDTH > hcbd_pkg::CLEN_W) ?
                                   SIZE_WIDTH : hcbd_pkg::CLEN_W,
  localparam int unsigned KEEP_W = $clog2(HEADER_KEEP + 1)
) (
  input  hcbd_pkg::in_item_t              item_i,
  input  logic                            length_mode_i,
  input  logic [hcbd_pkg::CLEN_W-1:0]     content_length_i,
  input  hcbd_pkg::ctl_t                  ctl_i,
  input  logic [ACC_W-1:0]                acc_i,
  input  logic [CNT_W-1:0]                rem_i,
  input  logic [KEEP_W-1:0]               kept_i,
  output hcbd_pkg::ctl_t                  ctl_o,
  output logic [ACC_W-1:0]                acc_o,
  output logic [CNT_W-1:0]                rem_o,
  output logic [KEEP_W-1:0]               kept_o,
  output logic                            res_valid_o,
  output hcbd_pkg::out_item_t             res_o
);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  logic [7:0]       ch;
  logic             is_hex;
  logic [3:0]       dig_val;
  logic             is_blank;
  logic             is_sign;

  always_comb begin
    ch       = item_i.in_byte;
    is_hex   = 1'b1;
    dig_val  = 4'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      dig_val = 4'(ch - 8'h30);
    end else if (ch inside {[8'h61:8'h66]}) begin
      dig_val = 4'(ch - 8'h57);
    end else if (ch inside {[8'h41:8'h46]}) begin
      dig_val = 4'(ch - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    is_blank = ch inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
    is_sign  = ch inside {CH_PLUS, CH_MINUS};
  end

  always_comb begin
    hcbd_pkg::ctl_t      c;
    logic [ACC_W-1:0]    acc_s;
    logic [ACC_W-1:0]    acc_n;
    logic [ACC_W+3:0]    sum;
    logic [ACC_W-1:0]    acc_dig;
    logic [CNT_W-1:0]    rem;
    logic [CNT_W-1:0]    rem_m1;
    logic [KEEP_W-1:0]   kept;
    logic                sign_path;

    c     = ctl_i;
    acc_s = acc_i;
    rem   = rem_i;
    kept  = kept_i;

    if (item_i.body_start) begin
      acc_s         = '0;
      kept          = '0;
      c.hex_step    = hcbd_pkg::HP_BLANK;
      c.negative    = 1'b0;
      c.digits_seen = 1'b0;
      c.trailer     = hcbd_pkg::TL_EMPTY;
      if (length_mode_i) begin
        rem     = CNT_W'(content_length_i);
        c.phase = (content_length_i != '0) ? hcbd_pkg::PH_FIXED : hcbd_pkg::PH_IDLE;
      end else begin
        rem     = '0;
        c.phase = hcbd_pkg::PH_SIZE;
      end
    end

    sum     = {acc_s, 4'b0000} + {{ACC_W{1'b0}}, dig_val};
    acc_dig = (|sum[ACC_W+3:ACC_W]) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    acc_n   = acc_s;
    rem_m1  = rem - CNT_W'(1);

    sign_path = ((c.hex_step == hcbd_pkg::HP_BLANK) && !is_blank && !is_sign) ||
                (c.hex_step == hcbd_pkg::HP_SIGN);

    res_valid_o = 1'b0;
    res_o       = '0;

    case (c.phase)
      hcbd_pkg::PH_SIZE: begin
        if (ch != CH_LF) begin
          if (kept < KEEP_W'(HEADER_KEEP)) begin
            kept = kept + KEEP_W'(1);
            if (sign_path) begin
              if (ch == CH_ZERO) begin
                c.digits_seen = 1'b1;
                c.hex_step    = hcbd_pkg::HP_ZERO;
              end else if (is_hex) begin
                acc_n         = acc_dig;
                c.digits_seen = 1'b1;
                c.hex_step    = hcbd_pkg::HP_DIGITS;
              end else begin
                c.hex_step = hcbd_pkg::HP_STOP;
              end
            end else begin
              case (c.hex_step)
                hcbd_pkg::HP_BLANK: begin
                  if (is_sign) begin
                    c.negative = (ch == CH_MINUS);
                    c.hex_step = hcbd_pkg::HP_SIGN;
                  end
                end
                hcbd_pkg::HP_ZERO: begin
                  if (ch == CH_LOW_X || ch == CH_UP_X) begin
                    c.hex_step = hcbd_pkg::HP_PREFIX;
                  end else if (is_hex) begin
                    acc_n         = acc_dig;
                    c.digits_seen = 1'b1;
                    c.hex_step    = hcbd_pkg::HP_DIGITS;
                  end else begin
                    c.hex_step = hcbd_pkg::HP_STOP;
                  end
                end
                hcbd_pkg::HP_PREFIX, hcbd_pkg::HP_DIGITS: begin
                  if (is_hex) begin
                    acc_n         = acc_dig;
                    c.digits_seen = 1'b1;
                    c.hex_step    = hcbd_pkg::HP_DIGITS;
                  end else begin
                    c.hex_step = hcbd_pkg::HP_STOP;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end else begin
          if (!c.digits_seen) begin
            c.phase        = hcbd_pkg::PH_IDLE;
            res_valid_o    = 1'b1;
            res_o.event_kind = hcbd_pkg::EV_FRAMING;
          end else if (c.negative || acc_s == '0) begin
            c.phase   = hcbd_pkg::PH_TRAILER;
            c.trailer = hcbd_pkg::TL_EMPTY;
          end else begin
            rem     = CNT_W'(acc_s);
            c.phase = hcbd_pkg::PH_DATA;
          end
          acc_n         = '0;
          kept          = '0;
          c.hex_step    = hcbd_pkg::HP_BLANK;
          c.negative    = 1'b0;
          c.digits_seen = 1'b0;
        end
      end
      hcbd_pkg::PH_DATA: begin
        rem = rem_m1;
        if (rem_m1 == '0) begin
          c.phase = hcbd_pkg::PH_SKIP1;
        end
        res_valid_o      = 1'b1;
        res_o.out_byte   = ch;
        res_o.event_kind = hcbd_pkg::EV_PAYLOAD;
      end
      hcbd_pkg::PH_SKIP1: begin
        c.phase = hcbd_pkg::PH_SKIP2;
      end
      hcbd_pkg::PH_SKIP2: begin
        c.phase       = hcbd_pkg::PH_SIZE;
        acc_n         = '0;
        kept          = '0;
        c.hex_step    = hcbd_pkg::HP_BLANK;
        c.negative    = 1'b0;
        c.digits_seen = 1'b0;
      end
      hcbd_pkg::PH_TRAILER: begin
        if (ch == CH_LF) begin
          if (c.trailer != hcbd_pkg::TL_OTHER) begin
            c.phase          = hcbd_pkg::PH_IDLE;
            res_valid_o      = 1'b1;
            res_o.event_kind = hcbd_pkg::EV_DONE;
          end else begin
            c.trailer = hcbd_pkg::TL_EMPTY;
          end
        end else if (c.trailer == hcbd_pkg::TL_EMPTY && ch == CH_CR) begin
          c.trailer = hcbd_pkg::TL_CR;
        end else begin
          c.trailer = hcbd_pkg::TL_OTHER;
        end
      end
      hcbd_pkg::PH_FIXED: begin
        if (rem == '0) begin
          c.phase = hcbd_pkg::PH_IDLE;
        end else begin
          rem            = rem_m1;
          res_valid_o    = 1'b1;
          res_o.out_byte = ch;
          if (rem_m1 == '0) begin
            c.phase          = hcbd_pkg::PH_IDLE;
            res_o.event_kind = hcbd_pkg::EV_FINAL;
          end else begin
            res_o.event_kind = hcbd_pkg::EV_PAYLOAD;
          end
        end
      end
      default: begin
      end
    endcase

    ctl_o  = c;
    acc_o  = acc_n;
    rem_o  = rem;
    kept_o = kept;
  end

endmodule

// ===== sv/http_chunked_body_decoder_core.sv =====
// Decodes an HTTP/1.1 response body one byte per clock, in chunked or fixed-length mode,
// the mode and the content length being sampled from the configuration registers on the byte
// that carries body_start. Every request passes an input register and a result register, so
// a byte that yields a result goes from the input register through the step logic into the
// result register, from where it is accepted. One byte is taken in every cycle as long as
// the output side is not stalled with a result waiting; the combinational update of the
// parser state, chunk counter and size accumulator sets that rate.
// No clearing pass follows reset, and configuration writes are taken in any cycle.
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_WIDTH  = hcbd_pkg::SIZE_WIDTH_DEF,
  parameter int unsigned HEADER_KEEP = hcbd_pkg::HEADER_KEEP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  hcbd_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output hcbd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hcbd_pkg::CLEN_W-1:0]       cfg_data_i
);

  localparam int unsigned ACC_W  = SIZE_WIDTH - 1;
  localparam int unsigned CNT_W  = (SIZE_WIDTH > hcbd_pkg::CLEN_W) ?
                                   SIZE_WIDTH : hcbd_pkg::CLEN_W;
  localparam int unsigned KEEP_W = $clog2(HEADER_KEEP + 1);

  localparam hcbd_pkg::ctl_t CTL_RESET = '{
    phase:       hcbd_pkg::PH_SIZE,
    hex_step:    hcbd_pkg::HP_BLANK,
    trailer:     hcbd_pkg::TL_EMPTY,
    negative:    1'b0,
    digits_seen: 1'b0
  };

  logic                          length_mode_q;
  logic [hcbd_pkg::CLEN_W-1:0]   content_length_q;

  logic                          in_valid_q, in_valid_d;
  hcbd_pkg::in_item_t            in_item_q;

  hcbd_pkg::ctl_t                ctl_q, ctl_d;
  logic [ACC_W-1:0]              acc_q, acc_d;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [KEEP_W-1:0]             kept_q, kept_d;

  logic                          out_valid_q, out_valid_d;
  hcbd_pkg::out_item_t           out_item_q;

  logic                          res_valid;
  hcbd_pkg::out_item_t           res;
  logic                          out_free;
  logic                          step_fire;
  logic                          in_take;

  hcbd_step #(
    .SIZE_WIDTH  (SIZE_WIDTH),
    .HEADER_KEEP (HEADER_KEEP)
  ) u_step (
    .item_i           (in_item_q),
    .length_mode_i    (length_mode_q),
    .content_length_i (content_length_q),
    .ctl_i            (ctl_q),
    .acc_i            (acc_q),
    .rem_i            (rem_q),
    .kept_i           (kept_q),
    .ctl_o            (ctl_d),
    .acc_o            (acc_d),
    .rem_o            (rem_d),
    .kept_o           (kept_d),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_fire = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !step_fire;
  assign in_take   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_mode_q    <= 1'b0;
      content_length_q <= hcbd_pkg::CLEN_W'(1);
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      ctl_q            <= CTL_RESET;
      acc_q            <= '0;
      rem_q            <= '0;
      kept_q           <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          hcbd_pkg::CFG_LENGTH_MODE: length_mode_q <= cfg_data_i[0];
          hcbd_pkg::CFG_CONTENT_LENGTH: content_length_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (step_fire) begin
        ctl_q  <= ctl_d;
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        kept_q <= kept_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (step_fire && res_valid) begin
      out_item_q <= res;
    end
  end

endmodule

// ===== sv/hcbd_checker.sv =====
`include "http_chunked_body_decoder_core_assert.svh"

module hcbd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input hcbd_pkg::out_item_t  out_item_o
);

  logic out_blocked;
  logic marker_event;
  logic byte_set;

  assign out_blocked  = out_valid_o && out_stall_i;
  assign marker_event = out_valid_o &&
                        (out_item_o.event_kind inside {hcbd_pkg::EV_DONE, hcbd_pkg::EV_FRAMING});
  assign byte_set     = |out_item_o.out_byte;

  `HCBD_ASSERT(a_out_hold, out_blocked |=> out_valid_o, "Stalled result vanished.")
  `HCBD_ASSERT_STABLE(a_out_data_hold, out_blocked, out_item_o, "Stalled result changed.")
  `HCBD_ASSERT(a_event_no_byte, marker_event |-> !byte_set, "Event carries a byte.")
  `HCBD_ASSERT(a_stall_cause, in_stall_o |-> out_blocked, "Stall without a blocked result.")

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (.*);
